// ----- src/pwfp_pkg.sv -----
`timescale 1ns / 1ps
package pwfp_pkg;

    // Longest varint accepted before an overlong error is raised
    localparam int unsigned MAX_VARINT_BYTES = 10;
    // Bytes that still land in the accumulator
    localparam logic [3:0] ACC_BYTES = 4'd10;
    localparam logic [3:0] MAX_BYTES = 4'(MAX_VARINT_BYTES);

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_VALUE   = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_SKIP    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    localparam logic [2:0] WIRE_VARINT  = 3'd0;
    localparam logic [2:0] WIRE_FIXED64 = 3'd1;
    localparam logic [2:0] WIRE_DELIM   = 3'd2;
    localparam logic [2:0] WIRE_FIXED32 = 3'd5;

    localparam logic [3:0] ERR_TAG_TRUNC     = 4'd0;
    localparam logic [3:0] ERR_TAG_WIDE      = 4'd1;
    localparam logic [3:0] ERR_VARINT_TRUNC  = 4'd2;
    localparam logic [3:0] ERR_FIXED64_TRUNC = 4'd3;
    localparam logic [3:0] ERR_LEN_TRUNC     = 4'd4;
    localparam logic [3:0] ERR_LEN_WIDE      = 4'd5;
    localparam logic [3:0] ERR_PAYLOAD_TRUNC = 4'd6;
    localparam logic [3:0] ERR_FIXED32_TRUNC = 4'd7;
    localparam logic [3:0] ERR_WIRE_TYPE     = 4'd8;
    localparam logic [3:0] ERR_VARINT_LONG   = 4'd9;

    // Results of one input byte: an optional header or payload result,
    // then an optional error result sharing field number and wire type
    typedef struct packed {
        logic        main_valid;
        logic        err_valid;
        kind_t       kind;
        logic [28:0] field_number;
        logic [2:0]  wire_type;
        logic [63:0] field_value;
        logic [7:0]  payload_byte;
        logic        last_of_field;
        logic [3:0]  error_code;
    } step_rec_t;

endpackage

// ----- src/pwfp_front.sv -----
`timescale 1ns / 1ps
module pwfp_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [7:0]          in_byte,
    input  logic                message_end,
    output logic                rec_push,
    output pwfp_pkg::step_rec_t rec
);

    pwfp_pkg::phase_t phase_reg, phase_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [28:0] fn_reg, fn_next;
    logic [2:0]  wt_reg, wt_next;
    logic [31:0] rem_reg, rem_next;

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pwfp_pkg::PH_TAG;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            fn_reg    <= '0;
            wt_reg    <= '0;
            rem_reg   <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            fn_reg    <= fn_next;
            wt_reg    <= wt_next;
            rem_reg   <= rem_next;
        end
    end

    // Classify one byte and build its result record
    always_comb
    begin
        logic [6:0]  shamt;
        logic        fail;
        logic [3:0]  code;
        logic        tag_ph;
        logic        last;
        shamt      = ({3'b0, cnt_reg} << 3) - {3'b0, cnt_reg};
        fail       = 1'b0;
        code       = pwfp_pkg::ERR_TAG_TRUNC;
        tag_ph     = (phase_reg == pwfp_pkg::PH_TAG);
        last       = 1'b0;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        fn_next    = fn_reg;
        wt_next    = wt_reg;
        rem_next   = rem_reg;
        rec        = '0;
        rec.kind   = pwfp_pkg::KIND_HEADER;
        rec.field_number = tag_ph ? 29'd0 : fn_reg;
        rec.wire_type    = tag_ph ? 3'd0 : wt_reg;

        unique case (phase_reg)
            pwfp_pkg::PH_TAG, pwfp_pkg::PH_VALUE, pwfp_pkg::PH_LENGTH:
            begin
                if (cnt_reg < pwfp_pkg::ACC_BYTES)
                begin
                    acc_next = acc_reg | ({57'b0, in_byte[6:0]} << shamt);
                    cnt_next = cnt_reg + 4'd1;
                end
                if (in_byte[7])
                begin
                    if (cnt_next >= pwfp_pkg::MAX_BYTES)
                    begin
                        fail = 1'b1;
                        code = pwfp_pkg::ERR_VARINT_LONG;
                    end
                    else if (message_end)
                    begin
                        fail = 1'b1;
                        code = tag_ph ? pwfp_pkg::ERR_TAG_TRUNC :
                               (phase_reg == pwfp_pkg::PH_VALUE) ?
                               pwfp_pkg::ERR_VARINT_TRUNC : pwfp_pkg::ERR_LEN_TRUNC;
                    end
                end
                else if (tag_ph)
                begin
                    if (acc_next[63:32] != 32'd0)
                    begin
                        fail = 1'b1;
                        code = pwfp_pkg::ERR_TAG_WIDE;
                    end
                    else
                    begin
                        fn_next  = acc_next[31:3];
                        wt_next  = acc_next[2:0];
                        acc_next = '0;
                        cnt_next = '0;
                        rec.field_number = fn_next;
                        rec.wire_type    = wt_next;
                        case (wt_next)
                            pwfp_pkg::WIRE_VARINT:
                            begin
                                phase_next = pwfp_pkg::PH_VALUE;
                                fail = message_end;
                                code = pwfp_pkg::ERR_VARINT_TRUNC;
                            end
                            pwfp_pkg::WIRE_FIXED64, pwfp_pkg::WIRE_FIXED32:
                            begin
                                rec.main_valid  = 1'b1;
                                rec.kind        = pwfp_pkg::KIND_HEADER;
                                rec.field_value = (wt_next == pwfp_pkg::WIRE_FIXED64) ?
                                                  64'd8 : 64'd4;
                                rem_next   = (wt_next == pwfp_pkg::WIRE_FIXED64) ?
                                             32'd8 : 32'd4;
                                phase_next = pwfp_pkg::PH_PAYLOAD;
                                fail = message_end;
                                code = (wt_next == pwfp_pkg::WIRE_FIXED64) ?
                                       pwfp_pkg::ERR_FIXED64_TRUNC :
                                       pwfp_pkg::ERR_FIXED32_TRUNC;
                            end
                            pwfp_pkg::WIRE_DELIM:
                            begin
                                phase_next = pwfp_pkg::PH_LENGTH;
                                fail = message_end;
                                code = pwfp_pkg::ERR_LEN_TRUNC;
                            end
                            default:
                            begin
                                fail = 1'b1;
                                code = pwfp_pkg::ERR_WIRE_TYPE;
                            end
                        endcase
                    end
                end
                else if (phase_reg == pwfp_pkg::PH_VALUE)
                begin
                    rec.main_valid    = 1'b1;
                    rec.field_value   = acc_next;
                    rec.last_of_field = 1'b1;
                    acc_next   = '0;
                    cnt_next   = '0;
                    phase_next = pwfp_pkg::PH_TAG;
                end
                else
                begin
                    if (acc_next[63:32] != 32'd0)
                    begin
                        fail = 1'b1;
                        code = pwfp_pkg::ERR_LEN_WIDE;
                    end
                    else
                    begin
                        rec.main_valid    = 1'b1;
                        rec.field_value   = acc_next;
                        rec.last_of_field = (acc_next == 64'd0);
                        if (acc_next == 64'd0)
                        begin
                            phase_next = pwfp_pkg::PH_TAG;
                        end
                        else
                        begin
                            rem_next   = acc_next[31:0];
                            phase_next = pwfp_pkg::PH_PAYLOAD;
                            fail = message_end;
                            code = pwfp_pkg::ERR_PAYLOAD_TRUNC;
                        end
                        acc_next = '0;
                        cnt_next = '0;
                    end
                end
            end
            pwfp_pkg::PH_PAYLOAD:
            begin
                last = (rem_reg <= 32'd1);
                rem_next          = last ? 32'd0 : rem_reg - 32'd1;
                rec.main_valid    = 1'b1;
                rec.kind          = pwfp_pkg::KIND_PAYLOAD;
                rec.payload_byte  = in_byte;
                rec.last_of_field = last;
                if (last)
                begin
                    phase_next = pwfp_pkg::PH_TAG;
                end
                else
                begin
                    fail = message_end;
                    code = (wt_reg == pwfp_pkg::WIRE_FIXED64) ? pwfp_pkg::ERR_FIXED64_TRUNC :
                           (wt_reg == pwfp_pkg::WIRE_FIXED32) ? pwfp_pkg::ERR_FIXED32_TRUNC :
                           pwfp_pkg::ERR_PAYLOAD_TRUNC;
                end
            end
            default:
            begin
                // Skip until message end
            end
        endcase

        // Raise an error and drop into skip
        if (fail)
        begin
            rec.err_valid  = 1'b1;
            rec.error_code = code;
            acc_next   = '0;
            cnt_next   = '0;
            rem_next   = '0;
            phase_next = pwfp_pkg::PH_SKIP;
        end

        // Restart at every message end
        if (message_end)
        begin
            phase_next = pwfp_pkg::PH_TAG;
            acc_next   = '0;
            cnt_next   = '0;
            rem_next   = '0;
        end
    end

    assign rec_push = in_fire && (rec.main_valid || rec.err_valid);

endmodule

// ----- src/pwfp_fifo.sv -----
`timescale 1ns / 1ps
module pwfp_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pwfp_pkg::step_rec_t push_data,
    input  logic                pop,
    output pwfp_pkg::step_rec_t pop_data,
    output logic                full,
    output logic                empty
);

    pwfp_pkg::step_rec_t mem [pwfp_pkg::FIFO_DEPTH];
    logic [pwfp_pkg::FIFO_AW-1:0] wr_reg, rd_reg;
    logic [pwfp_pkg::FIFO_AW:0]   cnt_reg, cnt_next;

    assign full     = (cnt_reg == (pwfp_pkg::FIFO_AW+1)'(pwfp_pkg::FIFO_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem[rd_reg];

    // Write entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- src/pwfp_back.sv -----
`timescale 1ns / 1ps
module pwfp_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  pwfp_pkg::step_rec_t rec,
    input  logic                rec_empty,
    output logic                rec_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          kind,
    output logic [28:0]         field_number,
    output logic [2:0]          wire_type,
    output logic [63:0]         field_value,
    output logic [7:0]          payload_byte,
    output logic                last_of_field,
    output logic [3:0]          error_code
);

    logic        valid_reg;
    logic        sub_reg;
    logic        load;
    logic        take_main;
    logic        final_part;
    logic [1:0]  kind_reg;
    logic [28:0] fn_reg;
    logic [2:0]  wt_reg;
    logic [63:0] val_reg;
    logic [7:0]  pb_reg;
    logic        last_reg;
    logic [3:0]  ec_reg;

    // Pick the next result of the head record
    assign load       = (!valid_reg || out_ready) && !rec_empty;
    assign take_main  = rec.main_valid && !sub_reg;
    assign final_part = !take_main || !rec.err_valid;
    assign rec_pop    = load && final_part;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= 1'b0;
        end
        else if (!valid_reg || out_ready)
        begin
            valid_reg <= !rec_empty;
            if (load)
            begin
                sub_reg <= !final_part;
            end
        end
    end

    // Hold the result until the transaction completes
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fn_reg <= rec.field_number;
            wt_reg <= rec.wire_type;
            if (take_main)
            begin
                kind_reg <= rec.kind;
                val_reg  <= rec.field_value;
                pb_reg   <= rec.payload_byte;
                last_reg <= rec.last_of_field;
                ec_reg   <= '0;
            end
            else
            begin
                kind_reg <= pwfp_pkg::KIND_ERROR;
                val_reg  <= '0;
                pb_reg   <= '0;
                last_reg <= 1'b1;
                ec_reg   <= rec.error_code;
            end
        end
    end

    assign out_valid     = valid_reg;
    assign kind          = kind_reg;
    assign field_number  = fn_reg;
    assign wire_type     = wt_reg;
    assign field_value   = val_reg;
    assign payload_byte  = pb_reg;
    assign last_of_field = last_reg;
    assign error_code    = ec_reg;

endmodule

// ----- src/protobuf_wire_field_parser_core.sv -----
`timescale 1ns / 1ps
// A result is written to the record queue when its byte is accepted, then loaded into the output register.
// Throughput: one byte per cycle while the record queue is not full; the output register drains one result
// per cycle while m_axis_tready is high, so a byte that yields a result and an error leaves as two results.
// The four-entry record queue between the parser and the output register sets the slack.
// Reset (rst_n low, asynchronous) returns the parser to the tag phase and empties the queue.
module protobuf_wire_field_parser_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] in_byte
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [28:0] field_number, [31:29] wire_type, [95:32] field_value,
    // [103:96] payload_byte, [107:104] error_code, [111:108] zero
    output logic [111:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // [1:0] kind
    output logic         m_axis_tlast
);

    logic                in_fire;
    logic                rec_push;
    logic                rec_pop;
    logic                q_full;
    logic                q_empty;
    pwfp_pkg::step_rec_t rec_in;
    pwfp_pkg::step_rec_t rec_out;
    logic [28:0]         field_number;
    logic [2:0]          wire_type;
    logic [63:0]         field_value;
    logic [7:0]          payload_byte;
    logic [3:0]          error_code;

    assign s_axis_tready = !q_full;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    pwfp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .in_byte     (s_axis_tdata),
        .message_end (s_axis_tlast),
        .rec_push    (rec_push),
        .rec         (rec_in)
    );

    pwfp_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_data (rec_in),
        .pop       (rec_pop),
        .pop_data  (rec_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    pwfp_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec           (rec_out),
        .rec_empty     (q_empty),
        .rec_pop       (rec_pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .kind          (m_axis_tuser),
        .field_number  (field_number),
        .wire_type     (wire_type),
        .field_value   (field_value),
        .payload_byte  (payload_byte),
        .last_of_field (m_axis_tlast),
        .error_code    (error_code)
    );

    // Pack result fields
    assign m_axis_tdata = {4'b0, error_code, payload_byte, field_value, wire_type, field_number};

endmodule
